// File: hw/rtl/cps_pkg.sv
package cps_pkg;

    // Item opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CYCLE = 2'd2;
    localparam logic [1:0] ST_NORUN = 2'd3;

    localparam int CFG_BITS = 9;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  from_vertex;
        logic [7:0]  to_vertex;
        logic [15:0] duration;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] earliest_start;
        logic signed [31:0] latest_start;
        logic [8:0]         successor;
    } out_item_t;

endpackage

// File: hw/rtl/cps_if.sv
interface cps_in_if import cps_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cps_out_if import cps_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/cps_ram.sv
module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/cps_alu.sv
module cps_alu #(
    parameter int TIME_BITS = 32
) (
    input  logic signed [TIME_BITS-1:0] a,
    input  logic [15:0]                 d,
    input  logic                        sub,
    output logic signed [TIME_BITS-1:0] y
);

    localparam int XW = TIME_BITS + 2;

    logic signed [XW-1:0] ax;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] s;
    logic signed [XW-1:0] tmax_x;
    logic signed [XW-1:0] tmin_x;

    // Saturating add or subtract of a duration
    always_comb
    begin
        ax     = {{2{a[TIME_BITS-1]}}, a};
        dx     = {{(XW-16){1'b0}}, d};
        tmax_x = {3'b000, {(TIME_BITS-1){1'b1}}};
        tmin_x = {3'b111, {(TIME_BITS-1){1'b0}}};
        s      = sub ? (ax - dx) : (ax + dx);
        if (s > tmax_x)
        begin
            y = tmax_x[TIME_BITS-1:0];
        end
        else if (s < tmin_x)
        begin
            y = tmin_x[TIME_BITS-1:0];
        end
        else
        begin
            y = s[TIME_BITS-1:0];
        end
    end

endmodule

// File: hw/rtl/cps_core.sv
module cps_core import cps_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int TIME_BITS    = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  in_item_t                             item,
    input  logic                                 cfg_we,
    input  logic [$clog2(MAX_VERTICES+1)-1:0]    vc,
    output logic                                 idle,
    output logic                                 done,
    output out_item_t                            res
);

    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int EIW = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int IDW = $clog2(MAX_EDGES + 1);
    localparam int SW  = $clog2(MAX_VERTICES + 1);
    localparam logic [SW-1:0] NO_SUCC = SW'(MAX_VERTICES);
    localparam logic signed [TIME_BITS-1:0] TMAX = {1'b0, {(TIME_BITS-1){1'b1}}};

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_READ   = 5'd1;
    localparam logic [4:0] S_INIT   = 5'd2;
    localparam logic [4:0] S_CNT_A  = 5'd3;
    localparam logic [4:0] S_CNT_B  = 5'd4;
    localparam logic [4:0] S_CNT_C  = 5'd5;
    localparam logic [4:0] S_SEED_A = 5'd6;
    localparam logic [4:0] S_SEED_B = 5'd7;
    localparam logic [4:0] S_FWD_A  = 5'd8;
    localparam logic [4:0] S_FWD_B  = 5'd9;
    localparam logic [4:0] S_FWD_C  = 5'd10;
    localparam logic [4:0] S_FE_A   = 5'd11;
    localparam logic [4:0] S_FE_B   = 5'd12;
    localparam logic [4:0] S_FE_C   = 5'd13;
    localparam logic [4:0] S_CHECK  = 5'd14;
    localparam logic [4:0] S_LAST_B = 5'd15;
    localparam logic [4:0] S_LAST_C = 5'd16;
    localparam logic [4:0] S_BWD_A  = 5'd17;
    localparam logic [4:0] S_BWD_B  = 5'd18;
    localparam logic [4:0] S_BWD_C  = 5'd19;
    localparam logic [4:0] S_BE_A   = 5'd20;
    localparam logic [4:0] S_BE_B   = 5'd21;
    localparam logic [4:0] S_BE_C   = 5'd22;

    logic [4:0]                  state_reg, state_next;
    logic [EIW-1:0]              loaded_reg, loaded_next;
    logic                        valid_reg, valid_next;
    logic [EIW-1:0]              e_reg, e_next;
    logic [VCW-1:0]              v_reg, v_next;
    logic [VCW-1:0]              oc_reg, oc_next;
    logic [VCW-1:0]              hd_reg, hd_next;
    logic [VAW-1:0]              from_reg, from_next;
    logic [VAW-1:0]              to_reg, to_next;
    logic [15:0]                 len_reg, len_next;
    logic signed [TIME_BITS-1:0] ef_reg, ef_next;
    logic signed [TIME_BITS-1:0] lf_reg, lf_next;
    logic [7:0]                  rd_id_reg, rd_id_next;

    // Memory ports
    logic            edge_we;
    logic [EAW-1:0]  edge_waddr, edge_raddr;
    logic [31:0]     edge_wdata, edge_rdata;
    logic            deg_we;
    logic [VAW-1:0]  deg_waddr, deg_raddr;
    logic [IDW-1:0]  deg_wdata, deg_rdata;
    logic            ear_we;
    logic [VAW-1:0]  ear_waddr, ear_raddr;
    logic [TIME_BITS-1:0] ear_wdata, ear_rdata;
    logic            lat_we;
    logic [VAW-1:0]  lat_waddr, lat_raddr;
    logic [TIME_BITS-1:0] lat_wdata, lat_rdata;
    logic            crit_we;
    logic [VAW-1:0]  crit_waddr, crit_raddr;
    logic [SW-1:0]   crit_wdata, crit_rdata;
    logic            topo_we;
    logic [VAW-1:0]  topo_waddr, topo_raddr;
    logic [VAW-1:0]  topo_wdata, topo_rdata;

    // Shared saturating unit
    logic signed [TIME_BITS-1:0] alu_a, alu_y;
    logic                        alu_sub;

    // Edge fields as read
    logic [7:0]     e_tail, e_head;
    logic [15:0]    e_len;
    logic           e_in_range;
    logic [IDW-1:0] deg_dec;

    cps_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );
    cps_ram #(.WIDTH(IDW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .raddr(deg_raddr), .rdata(deg_rdata)
    );
    cps_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_VERTICES)) u_ear_ram (
        .clk(clk), .we(ear_we), .waddr(ear_waddr), .wdata(ear_wdata),
        .raddr(ear_raddr), .rdata(ear_rdata)
    );
    cps_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_VERTICES)) u_lat_ram (
        .clk(clk), .we(lat_we), .waddr(lat_waddr), .wdata(lat_wdata),
        .raddr(lat_raddr), .rdata(lat_rdata)
    );
    cps_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_crit_ram (
        .clk(clk), .we(crit_we), .waddr(crit_waddr), .wdata(crit_wdata),
        .raddr(crit_raddr), .rdata(crit_rdata)
    );
    cps_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES)) u_topo_ram (
        .clk(clk), .we(topo_we), .waddr(topo_waddr), .wdata(topo_wdata),
        .raddr(topo_raddr), .rdata(topo_rdata)
    );

    cps_alu #(.TIME_BITS(TIME_BITS)) u_alu (
        .a(alu_a), .d(len_reg), .sub(alu_sub), .y(alu_y)
    );

    assign e_tail     = edge_rdata[31:24];
    assign e_head     = edge_rdata[23:16];
    assign e_len      = edge_rdata[15:0];
    assign e_in_range = (32'(e_tail) < 32'(vc)) && (32'(e_head) < 32'(vc));
    assign deg_dec    = deg_rdata - IDW'(1);
    assign idle       = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        valid_next  = valid_reg;
        e_next      = e_reg;
        v_next      = v_reg;
        oc_next     = oc_reg;
        hd_next     = hd_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        len_next    = len_reg;
        ef_next     = ef_reg;
        lf_next     = lf_reg;
        rd_id_next  = rd_id_reg;

        edge_we    = 1'b0;
        edge_waddr = loaded_reg[EAW-1:0];
        edge_wdata = {item.from_vertex, item.to_vertex, item.duration};
        edge_raddr = e_reg[EAW-1:0];
        deg_we     = 1'b0;
        deg_waddr  = to_reg;
        deg_wdata  = '0;
        deg_raddr  = v_reg[VAW-1:0];
        ear_we     = 1'b0;
        ear_waddr  = to_reg;
        ear_wdata  = alu_y;
        ear_raddr  = from_reg;
        lat_we     = 1'b0;
        lat_waddr  = from_reg;
        lat_wdata  = alu_y;
        lat_raddr  = from_reg;
        crit_we    = 1'b0;
        crit_waddr = from_reg;
        crit_wdata = NO_SUCC;
        crit_raddr = VAW'(rd_id_reg);
        topo_we    = 1'b0;
        topo_waddr = oc_reg[VAW-1:0];
        topo_wdata = to_reg;
        topo_raddr = hd_reg[VAW-1:0];

        alu_a   = ef_reg;
        alu_sub = 1'b0;

        done = 1'b0;
        res  = '{status: ST_OK, earliest_start: '0, latest_start: '0,
                 successor: 9'(NO_SUCC)};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (item.op)
                        OP_LOAD:
                        begin
                            valid_next = 1'b0;
                            done       = 1'b1;
                            if (32'(loaded_reg) >= 32'(MAX_EDGES))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                edge_we     = 1'b1;
                                loaded_next = loaded_reg + EIW'(1);
                            end
                        end
                        OP_RUN:
                        begin
                            valid_next = 1'b0;
                            v_next     = '0;
                            state_next = S_INIT;
                        end
                        OP_READ:
                        begin
                            rd_id_next = item.from_vertex;
                            ear_raddr  = VAW'(item.from_vertex);
                            lat_raddr  = VAW'(item.from_vertex);
                            crit_raddr = VAW'(item.from_vertex);
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            loaded_next = '0;
                            valid_next  = 1'b0;
                            done        = 1'b1;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end

            // Per-vertex results
            S_READ:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
                if (!valid_reg || (32'(rd_id_reg) >= 32'(vc)))
                begin
                    res.status = ST_NORUN;
                end
                else
                begin
                    res.earliest_start = 32'($signed(ear_rdata));
                    res.latest_start   = 32'($signed(lat_rdata));
                    res.successor      = 9'(crit_rdata);
                end
            end

            // Reset all vertex records in use
            S_INIT:
            begin
                deg_we     = 1'b1;
                deg_waddr  = v_reg[VAW-1:0];
                deg_wdata  = '0;
                ear_we     = 1'b1;
                ear_waddr  = v_reg[VAW-1:0];
                ear_wdata  = '0;
                lat_we     = 1'b1;
                lat_waddr  = v_reg[VAW-1:0];
                lat_wdata  = TMAX;
                crit_we    = 1'b1;
                crit_waddr = v_reg[VAW-1:0];
                crit_wdata = NO_SUCC;
                v_next     = v_reg + VCW'(1);
                if (v_reg + VCW'(1) == vc)
                begin
                    e_next     = '0;
                    state_next = S_CNT_A;
                end
            end

            // In-degree count over the edge table
            S_CNT_A:
            begin
                if (e_reg == loaded_reg)
                begin
                    v_next     = '0;
                    oc_next    = '0;
                    state_next = S_SEED_A;
                end
                else
                begin
                    state_next = S_CNT_B;
                end
            end
            S_CNT_B:
            begin
                if (e_in_range)
                begin
                    to_next    = VAW'(e_head);
                    deg_raddr  = VAW'(e_head);
                    state_next = S_CNT_C;
                end
                else
                begin
                    e_next     = e_reg + EIW'(1);
                    state_next = S_CNT_A;
                end
            end
            S_CNT_C:
            begin
                deg_we     = 1'b1;
                deg_wdata  = deg_rdata + IDW'(1);
                e_next     = e_reg + EIW'(1);
                state_next = S_CNT_A;
            end

            // Seed the order with sources in ascending id
            S_SEED_A:
            begin
                if (v_reg == vc)
                begin
                    hd_next    = '0;
                    state_next = S_FWD_A;
                end
                else
                begin
                    state_next = S_SEED_B;
                end
            end
            S_SEED_B:
            begin
                if (deg_rdata == '0)
                begin
                    topo_we    = 1'b1;
                    topo_wdata = v_reg[VAW-1:0];
                    oc_next    = oc_reg + VCW'(1);
                end
                v_next     = v_reg + VCW'(1);
                state_next = S_SEED_A;
            end

            // Forward pass: pop next ordered vertex
            S_FWD_A:
            begin
                if (hd_reg == oc_reg)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FWD_B;
                end
            end
            S_FWD_B:
            begin
                from_next  = topo_rdata;
                ear_raddr  = topo_rdata;
                state_next = S_FWD_C;
            end
            S_FWD_C:
            begin
                ef_next    = $signed(ear_rdata);
                e_next     = '0;
                state_next = S_FE_A;
            end
            S_FE_A:
            begin
                if (e_reg == loaded_reg)
                begin
                    hd_next    = hd_reg + VCW'(1);
                    state_next = S_FWD_A;
                end
                else
                begin
                    state_next = S_FE_B;
                end
            end
            S_FE_B:
            begin
                if (e_in_range && (32'(e_tail) == 32'(from_reg)))
                begin
                    to_next    = VAW'(e_head);
                    len_next   = e_len;
                    ear_raddr  = VAW'(e_head);
                    deg_raddr  = VAW'(e_head);
                    state_next = S_FE_C;
                end
                else
                begin
                    e_next     = e_reg + EIW'(1);
                    state_next = S_FE_A;
                end
            end
            S_FE_C:
            begin
                if ($signed(ear_rdata) < alu_y)
                begin
                    ear_we = 1'b1;
                end
                deg_we    = 1'b1;
                deg_wdata = deg_dec;
                if ((deg_dec == '0) && (32'(oc_reg) < 32'(MAX_VERTICES)))
                begin
                    topo_we = 1'b1;
                    oc_next = oc_reg + VCW'(1);
                end
                e_next     = e_reg + EIW'(1);
                state_next = S_FE_A;
            end

            // Order complete? then seed latest of the last vertex
            S_CHECK:
            begin
                if (oc_reg < vc)
                begin
                    done       = 1'b1;
                    res.status = ST_CYCLE;
                    state_next = S_IDLE;
                end
                else
                begin
                    topo_raddr = VAW'(oc_reg - VCW'(1));
                    state_next = S_LAST_B;
                end
            end
            S_LAST_B:
            begin
                from_next  = topo_rdata;
                ear_raddr  = topo_rdata;
                state_next = S_LAST_C;
            end
            S_LAST_C:
            begin
                lat_we     = 1'b1;
                lat_wdata  = ear_rdata;
                hd_next    = oc_reg - VCW'(1);
                state_next = S_BWD_A;
            end

            // Backward pass over the order
            S_BWD_A:
            begin
                if (hd_reg == '0)
                begin
                    valid_next = 1'b1;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    topo_raddr = VAW'(hd_reg - VCW'(1));
                    state_next = S_BWD_B;
                end
            end
            S_BWD_B:
            begin
                from_next  = topo_rdata;
                ear_raddr  = topo_rdata;
                lat_raddr  = topo_rdata;
                state_next = S_BWD_C;
            end
            S_BWD_C:
            begin
                ef_next    = $signed(ear_rdata);
                lf_next    = $signed(lat_rdata);
                e_next     = '0;
                state_next = S_BE_A;
            end
            S_BE_A:
            begin
                if (e_reg == loaded_reg)
                begin
                    hd_next    = hd_reg - VCW'(1);
                    state_next = S_BWD_A;
                end
                else
                begin
                    state_next = S_BE_B;
                end
            end
            S_BE_B:
            begin
                if (e_in_range && (32'(e_tail) == 32'(from_reg)))
                begin
                    to_next    = VAW'(e_head);
                    len_next   = e_len;
                    lat_raddr  = VAW'(e_head);
                    state_next = S_BE_C;
                end
                else
                begin
                    e_next     = e_reg + EIW'(1);
                    state_next = S_BE_A;
                end
            end
            S_BE_C:
            begin
                alu_a      = $signed(lat_rdata);
                alu_sub    = 1'b1;
                e_next     = e_reg + EIW'(1);
                state_next = S_BE_A;
                if (lf_reg > alu_y)
                begin
                    lf_next = alu_y;
                    lat_we  = 1'b1;
                    if (alu_y == ef_reg)
                    begin
                        crit_we    = 1'b1;
                        crit_wdata = SW'(to_reg);
                        hd_next    = hd_reg - VCW'(1);
                        state_next = S_BWD_A;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Register writes invalidate any finished schedule
        if (cfg_we)
        begin
            valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            loaded_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            valid_reg  <= valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        v_reg     <= v_next;
        oc_reg    <= oc_next;
        hd_reg    <= hd_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        len_reg   <= len_next;
        ef_reg    <= ef_next;
        lf_reg    <= lf_next;
        rd_id_reg <= rd_id_next;
    end

endmodule

// File: hw/rtl/critical_path_schedule.sv
// Load and clear beats are answered from the idle state, reads from a separate read state.
// A run is paced by the single shared saturating adder and the one read port of each table.
// One beat is in flight at a time; the input is not ready until the result is taken.
// Reset clears the edge count, the schedule-valid flag and sets vertex_count to 1;
// table contents are not cleared.
module critical_path_schedule import cps_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int TIME_BITS    = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    cps_in_if.sink              in_ch,
    cps_out_if.source           out_ch,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int VCW = $clog2(MAX_VERTICES + 1);

    logic [VCW-1:0] vc_reg;
    logic           out_valid_reg;
    out_item_t      out_data_reg;
    logic           core_idle;
    logic           core_done;
    out_item_t      core_res;
    logic           start;

    assign in_ch.ready  = core_idle && !out_valid_reg;
    assign start        = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    cps_core #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES),
        .TIME_BITS(TIME_BITS)
    ) u_core (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .item(in_ch.data),
        .cfg_we(cfg_we),
        .vc(vc_reg),
        .idle(core_idle),
        .done(core_done),
        .res(core_res)
    );

    // Vertex count register, clamped to 1..MAX_VERTICES
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VCW'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                vc_reg <= VCW'(1);
            end
            else if (32'(cfg_data) > 32'(MAX_VERTICES))
            begin
                vc_reg <= VCW'(MAX_VERTICES);
            end
            else
            begin
                vc_reg <= VCW'(cfg_data);
            end
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            out_data_reg <= core_res;
        end
    end

endmodule
